[hdl/pulse_flow_rate_monitor_assert.svh]
// Assertion macros for the pulse flow rate monitor.
`ifndef PULSE_FLOW_RATE_MONITOR_ASSERT_SVH
`define PULSE_FLOW_RATE_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS
`define PRFM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PRFM_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) cond |=> cons) else $error(msg);
`else
`define PRFM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PRFM_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg)
`endif

`endif

[hdl/prfm_pkg.sv]
// Shared types and constants of the pulse flow rate monitor.
package prfm_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    localparam int PULSE_W    = 8;
    localparam int STAMP_W    = 32;
    localparam int RATIO_W    = 20;
    localparam int NOM_W      = 31;
    localparam int LIMIT_W    = 8;
    localparam int RATE_W     = 31;
    localparam int PROD_W     = RATIO_W + PULSE_W;
    localparam int VOL_W      = PROD_W + 10;
    localparam int MS_PER_S   = 1000;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // whole seconds: elapsed * RECIP_MS >> RECIP_SH is exact below 2^SECS_IN_W ms;
    // from SECS_CAP_MS up the seconds exceed any ratio, so SECS_CAP stands in
    localparam int SECS_W      = RATIO_W + 1;
    localparam int SECS_IN_W   = 30;
    localparam int RECIP_W     = 29;
    localparam int RECIP_SH    = 38;
    localparam int SECS_PROD_W = SECS_IN_W + RECIP_W;
    localparam int SECS_CAP_MS = MS_PER_S << RATIO_W;

    localparam logic [RATE_W-1:0]  RATE_MAX   = {RATE_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_RST  = RATIO_W'(1000);
    localparam logic [NOM_W-1:0]   NOM_RST    = {NOM_W{1'b1}};
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(3);
    localparam logic [LIMIT_W-1:0] MISS_SAT   = {LIMIT_W{1'b1}};
    localparam logic [RECIP_W-1:0] RECIP_MS   = RECIP_W'(274877907);
    localparam logic [SECS_W-1:0]  SECS_CAP   = {1'b1, {RATIO_W{1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_RATIO   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV_VOL,
        ST_SECS,
        ST_DIV_RATE,
        ST_SEND
    } t_state;

    typedef enum logic [1:0] {
        DIV_VOL,
        DIV_RATE
    } t_div_sel;

    typedef enum logic [1:0] {
        RATE_HOLD,
        RATE_SAT_MAX,
        RATE_HALF,
        RATE_QUO
    } t_rate_op;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_STEP,
        CNT_CLEAR
    } t_cnt_op;

    typedef struct packed {
        logic     load_in;
        logic     div_start;
        t_div_sel div_sel;
        t_rate_op rate_op;
        t_cnt_op  cnt_op;
        logic     load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic has_pulses;
        logic diff_bad;
        logic timeout;
        logic limit_hit;
        logic short_elapsed;
        logic div_done;
        logic out_free;
    } t_dp_sts;

endpackage

[hdl/prfm_if.sv]
// Channel interfaces: configuration writes, update items and results.
interface prfm_cfg_if import prfm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface prfm_upd_if import prfm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PULSE_W-1:0] pulse_count;
    logic [STAMP_W-1:0] first_stamp_ms;
    logic [STAMP_W-1:0] last_stamp_ms;
    logic [STAMP_W-1:0] now_ms;

    modport source (output valid, output pulse_count, output first_stamp_ms,
                    output last_stamp_ms, output now_ms, input ready);
    modport sink   (input valid, input pulse_count, input first_stamp_ms,
                    input last_stamp_ms, input now_ms, output ready);
endinterface

interface prfm_res_if import prfm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [RATE_W-1:0]  flow_rate_ml_per_s;
    logic [STAMP_W-1:0] interval_ms;
    logic [LIMIT_W-1:0] missed_count;
    logic               pulse_timeout;
    logic [STAMP_W-1:0] first_stamp_out;
    logic [STAMP_W-1:0] last_stamp_out;

    modport source (output valid, output flow_rate_ml_per_s, output interval_ms,
                    output missed_count, output pulse_timeout, output first_stamp_out,
                    output last_stamp_out, input ready);
    modport sink   (input valid, input flow_rate_ml_per_s, input interval_ms,
                    input missed_count, input pulse_timeout, input first_stamp_out,
                    input last_stamp_out, output ready);
endinterface

[hdl/pulse_flow_rate_monitor.sv]
// Top level of the pulse flow rate monitor.
//
//  channel   dir  handshake     payload
//  i_cfg     in   valid/ready   index, data (ratio, nominal interval, missed limit)
//  i_upd     in   valid/ready   pulse_count, first/last stamps, now
//  o_res     out  valid/ready   rate, interval, missed count, timeout, stamps
//
// One update transaction at a time; the rate division and re-estimation use the shared
// divider (DIV_W = max(38, TIME_WIDTH), one quotient bit per cycle; whole seconds come
// from a reciprocal multiply).
// Reset restores register defaults and clears rate and missed count; no clearing pass.
// A finished result waits in the output register; the next update is taken meanwhile.
// Configuration writes are always ready.
module pulse_flow_rate_monitor import prfm_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    prfm_cfg_if.sink    i_cfg,
    prfm_upd_if.sink    i_upd,
    prfm_res_if.source  o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_upd.ready = w_in_ready;

    prfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_upd.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    prfm_dp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg.valid),
        .i_cfg_index          (i_cfg.index),
        .i_cfg_data           (i_cfg.data),
        .i_pulse_count        (i_upd.pulse_count),
        .i_first_stamp_ms     (i_upd.first_stamp_ms),
        .i_last_stamp_ms      (i_upd.last_stamp_ms),
        .i_now_ms             (i_upd.now_ms),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_out_ready          (o_res.ready),
        .o_out_valid          (o_res.valid),
        .o_flow_rate_ml_per_s (o_res.flow_rate_ml_per_s),
        .o_interval_ms        (o_res.interval_ms),
        .o_missed_count       (o_res.missed_count),
        .o_pulse_timeout      (o_res.pulse_timeout),
        .o_first_stamp_out    (o_res.first_stamp_out),
        .o_last_stamp_out     (o_res.last_stamp_out)
    );

endmodule

[hdl/prfm_div.sv]
// Restoring divider, one quotient bit per cycle.
module prfm_div import prfm_pkg::*; #(
    parameter int DIV_W = VOL_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_busy,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W:0]   w_sh;
    logic [DIV_W+1:0] w_sub;
    logic             w_ge;

    assign o_busy     = (r_cnt != '0);
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_comb begin
        w_sh  = {r_rem, r_quo[DIV_W-1]};
        w_sub = {1'b0, w_sh} - {2'b00, r_dvs};
        w_ge  = ~w_sub[DIV_W+1];
        n_rem = w_ge ? w_sub[DIV_W-1:0] : w_sh[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_W);
            end else if (o_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (o_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

endmodule

[hdl/prfm_ctrl.sv]
// Sequencer for one update transaction.
module prfm_ctrl import prfm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.load_in   = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.div_sel   = DIV_VOL;
        o_cmd.rate_op   = RATE_HOLD;
        o_cmd.cnt_op    = CNT_HOLD;
        o_cmd.load_out  = 1'b0;
        unique case (r_state) inside
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_sts.has_pulses) begin
                    if (i_sts.diff_bad) begin
                        o_cmd.rate_op = RATE_SAT_MAX;
                        n_state       = ST_SEND;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_sel   = DIV_VOL;
                        n_state         = ST_DIV_VOL;
                    end
                end else if (!i_sts.timeout) begin
                    n_state = ST_SEND;
                end else if (!i_sts.limit_hit) begin
                    o_cmd.rate_op = RATE_HALF;
                    o_cmd.cnt_op  = CNT_STEP;
                    n_state       = ST_SEND;
                end else begin
                    o_cmd.cnt_op = CNT_CLEAR;
                    if (i_sts.short_elapsed) begin
                        o_cmd.rate_op = RATE_SAT_MAX;
                        n_state       = ST_SEND;
                    end else begin
                        n_state = ST_SECS;
                    end
                end
            end
            ST_DIV_VOL, ST_DIV_RATE: begin
                if (i_sts.div_done) begin
                    o_cmd.rate_op = RATE_QUO;
                    n_state       = ST_SEND;
                end
            end
            ST_SECS: begin
                // whole seconds registered, now ratio over seconds
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_RATE;
                n_state         = ST_DIV_RATE;
            end
            ST_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/prfm_dp.sv]
// Datapath: configuration, input capture, rate and miss state, result register.
`include "pulse_flow_rate_monitor_assert.svh"

module prfm_dp import prfm_pkg::*; #(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [PULSE_W-1:0]    i_pulse_count,
    input  logic [STAMP_W-1:0]    i_first_stamp_ms,
    input  logic [STAMP_W-1:0]    i_last_stamp_ms,
    input  logic [STAMP_W-1:0]    i_now_ms,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [RATE_W-1:0]     o_flow_rate_ml_per_s,
    output logic [STAMP_W-1:0]    o_interval_ms,
    output logic [LIMIT_W-1:0]    o_missed_count,
    output logic                  o_pulse_timeout,
    output logic [STAMP_W-1:0]    o_first_stamp_out,
    output logic [STAMP_W-1:0]    o_last_stamp_out
);

    localparam int TW     = TIME_WIDTH;
    localparam int DIV_W  = (TW > VOL_W) ? TW : VOL_W;
    localparam int CMP_W  = (TW > NOM_W) ? TW : NOM_W;
    localparam int ELAP_W = (TW > 32) ? TW : 32;

    logic [RATIO_W-1:0] r_ratio;
    logic [NOM_W-1:0]   r_nominal;
    logic [LIMIT_W-1:0] r_limit;
    logic [RATE_W-1:0]  r_rate;
    logic [LIMIT_W-1:0] r_miss;
    logic [RATE_W-1:0]  n_rate;
    logic [LIMIT_W-1:0] n_miss;
    logic [SECS_W-1:0]  r_secs;
    logic [SECS_W-1:0]  n_secs;

    logic [PULSE_W-1:0] r_pulses;
    logic [PROD_W-1:0]  r_prod;
    logic [TW-1:0]      r_first;
    logic [TW-1:0]      r_last;
    logic [TW-1:0]      r_now;

    logic               r_out_valid;
    logic [RATE_W-1:0]  r_out_rate;
    logic [STAMP_W-1:0] r_out_interval;
    logic [LIMIT_W-1:0] r_out_miss;
    logic               r_out_timeout;
    logic [STAMP_W-1:0] r_out_first;
    logic [STAMP_W-1:0] r_out_last;

    logic                   w_has;
    logic [TW-1:0]          w_diff;
    logic                   w_zero;
    logic [TW-1:0]          w_first_eff;
    logic [TW-1:0]          w_last_eff;
    logic [TW-1:0]          w_elapsed;
    logic [ELAP_W-1:0]      w_elap_ext;
    logic                   w_secs_big;
    logic [SECS_PROD_W-1:0] w_secs_prod;
    logic                   w_timeout;
    logic [LIMIT_W-1:0]     w_miss_inc;
    logic [VOL_W-1:0]       w_vol;
    logic [DIV_W-1:0]       w_dividend;
    logic [DIV_W-1:0]       w_divisor;
    logic [DIV_W-1:0]       w_quo;
    logic [RATE_W-1:0]      w_quo_sat;
    logic                   w_div_busy;
    logic                   w_div_done;
    logic                   w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio   <= RATIO_RST;
            r_nominal <= NOM_RST;
            r_limit   <= LIMIT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RATIO:   r_ratio   <= i_cfg_data[RATIO_W-1:0];
                CFG_NOMINAL: r_nominal <= i_cfg_data[NOM_W-1:0];
                CFG_LIMIT:   r_limit   <= i_cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_pulses <= i_pulse_count;
            r_prod   <= PROD_W'(r_ratio) * PROD_W'(i_pulse_count);
            r_first  <= TW'(i_first_stamp_ms);
            r_last   <= TW'(i_last_stamp_ms);
            r_now    <= TW'(i_now_ms);
        end
    end

    always_comb begin
        w_has       = (r_pulses != '0);
        w_diff      = r_last - r_first;
        w_zero      = (r_first == '0) && (r_last == '0);
        w_first_eff = (!w_has && w_zero) ? r_now : r_first;
        w_last_eff  = (!w_has && w_zero) ? r_now : r_last;
        w_elapsed   = r_now - w_last_eff;
        w_elap_ext  = ELAP_W'(w_elapsed);
        w_secs_big  = (w_elap_ext >= ELAP_W'(SECS_CAP_MS));
        w_secs_prod = SECS_PROD_W'(w_elap_ext[SECS_IN_W-1:0]) * SECS_PROD_W'(RECIP_MS);
        n_secs      = w_secs_big ? SECS_CAP : w_secs_prod[RECIP_SH +: SECS_W];
        w_timeout   = !w_has && (CMP_W'(w_elapsed) > CMP_W'(r_nominal));
        w_miss_inc  = (r_miss == MISS_SAT) ? r_miss : r_miss + LIMIT_W'(1);
        w_vol       = VOL_W'(r_prod) * VOL_W'(MS_PER_S);
        w_quo_sat   = (w_quo > DIV_W'(RATE_MAX)) ? RATE_MAX : w_quo[RATE_W-1:0];
        w_out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        r_secs <= n_secs;
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_VOL: begin
                w_dividend = DIV_W'(w_vol);
                w_divisor  = DIV_W'(w_diff);
            end
            default: begin
                w_dividend = DIV_W'(r_ratio);
                w_divisor  = DIV_W'(r_secs);
            end
        endcase
    end

    prfm_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        case (i_cmd.rate_op)
            RATE_SAT_MAX: n_rate = RATE_MAX;
            RATE_HALF:    n_rate = r_rate >> 1;
            RATE_QUO:     n_rate = w_quo_sat;
            default:      n_rate = r_rate;
        endcase
        case (i_cmd.cnt_op)
            CNT_STEP:  n_miss = w_miss_inc;
            CNT_CLEAR: n_miss = '0;
            default:   n_miss = r_miss;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate      <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rate <= n_rate;
            r_miss <= n_miss;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_rate     <= r_rate;
            r_out_interval <= w_has ? STAMP_W'(w_diff) : STAMP_W'(w_elapsed);
            r_out_miss     <= r_miss;
            r_out_timeout  <= w_timeout;
            r_out_first    <= STAMP_W'(w_first_eff);
            r_out_last     <= STAMP_W'(w_last_eff);
        end
    end

    assign o_sts.has_pulses    = w_has;
    assign o_sts.diff_bad      = (w_diff == '0) || w_diff[TW-1];
    assign o_sts.timeout       = w_timeout;
    assign o_sts.limit_hit     = (w_miss_inc >= r_limit);
    assign o_sts.short_elapsed = (w_elapsed < TW'(MS_PER_S));
    assign o_sts.div_done      = w_div_done;
    assign o_sts.out_free      = w_out_free;

    assign o_out_valid          = r_out_valid;
    assign o_flow_rate_ml_per_s = r_out_rate;
    assign o_interval_ms        = r_out_interval;
    assign o_missed_count       = r_out_miss;
    assign o_pulse_timeout      = r_out_timeout;
    assign o_first_stamp_out    = r_out_first;
    assign o_last_stamp_out     = r_out_last;

    `PRFM_ASSERT(a_div_start_idle, i_clk, i_rst_n, i_cmd.div_start |-> !w_div_busy, "divider started while busy")
    `PRFM_ASSERT(a_out_no_overwrite, i_clk, i_rst_n, i_cmd.load_out |-> w_out_free, "result register overwritten")
    `PRFM_ASSERT_NEXT(a_quo_on_done, i_clk, i_rst_n, i_cmd.rate_op == RATE_QUO, $past(w_div_done), "quotient taken before divider finished")

endmodule

[sim/tb_pulse_flow_rate_monitor.sv]
// Self-checking testbench of the pulse flow rate monitor: directed and random updates.
`timescale 1ns / 100ps

module tb_pulse_flow_rate_monitor import prfm_pkg::*;;

    localparam int IDLE_PCT       = 11;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 100;
    localparam int DRAIN_CYCLES   = 200;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 152;
    localparam int CALM_PHASE     = 5;
    localparam int PRESSURE_PHASE = 3;
    localparam int MAX_REPORTS    = 50;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PULSE_W-1:0] pulses;
        logic [STAMP_W-1:0] first_ms;
        logic [STAMP_W-1:0] last_ms;
        logic [STAMP_W-1:0] now_ms;
    } t_flow_update;

    typedef struct packed {
        logic [RATE_W-1:0]  rate;
        logic [STAMP_W-1:0] interval;
        logic [LIMIT_W-1:0] missed;
        logic               timeout;
        logic [STAMP_W-1:0] first_out;
        logic [STAMP_W-1:0] last_out;
    } t_flow_result;

    class flow_scoreboard;
        logic [RATIO_W-1:0] ratio;
        logic [NOM_W-1:0]   nominal;
        logic [LIMIT_W-1:0] limit;
        logic [RATE_W-1:0]  rate;
        logic [LIMIT_W-1:0] misses;
        t_flow_result       expected_q[$];
        int                 errors;

        function new();
            ratio   = RATIO_RST;
            nominal = NOM_RST;
            limit   = LIMIT_RST;
            rate    = '0;
            misses  = '0;
            errors  = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RATIO:   ratio   = data[RATIO_W-1:0];
                CFG_NOMINAL: nominal = data[NOM_W-1:0];
                CFG_LIMIT:   limit   = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_update(t_flow_update u);
            t_flow_result       r;
            logic [STAMP_W-1:0] first_ms;
            logic [STAMP_W-1:0] last_ms;
            logic [STAMP_W-1:0] span;
            logic [STAMP_W-1:0] secs;
            logic [63:0]        quotient;
            first_ms  = u.first_ms;
            last_ms   = u.last_ms;
            r.timeout = 1'b0;
            if (u.pulses != 0) begin
                span       = last_ms - first_ms;
                r.interval = span;
                if (span == 0 || span[STAMP_W-1]) begin
                    rate = RATE_MAX;
                end else begin
                    quotient = (64'(ratio) * 64'(u.pulses) * 64'(MS_PER_S)) / 64'(span);
                    rate     = (quotient > 64'(RATE_MAX)) ? RATE_MAX : quotient[RATE_W-1:0];
                end
            end else begin
                if (first_ms == 0 && last_ms == 0) begin
                    first_ms = u.now_ms;
                    last_ms  = u.now_ms;
                end
                span       = u.now_ms - last_ms;
                r.interval = span;
                if (span > 32'(nominal)) begin
                    r.timeout = 1'b1;
                    rate      = rate >> 1;
                    if (misses != MISS_SAT)
                        misses = misses + 1'b1;
                    if (misses >= limit) begin
                        misses = '0;
                        secs   = span / 32'(MS_PER_S);
                        rate   = (secs == 0) ? RATE_MAX : RATE_W'(32'(ratio) / secs);
                    end
                end
            end
            r.rate      = rate;
            r.missed    = misses;
            r.first_out = first_ms;
            r.last_out  = last_ms;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(t_flow_result got);
            t_flow_result want;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no update outstanding");
                return;
            end
            want = expected_q.pop_front();
            if (got.rate !== want.rate)
                report_mismatch($sformatf("rate %0d, expected %0d", got.rate, want.rate));
            if (got.interval !== want.interval)
                report_mismatch($sformatf("interval %0h, expected %0h",
                                          got.interval, want.interval));
            if (got.missed !== want.missed)
                report_mismatch($sformatf("missed count %0d, expected %0d",
                                          got.missed, want.missed));
            if (got.timeout !== want.timeout)
                report_mismatch($sformatf("timeout %0b, expected %0b",
                                          got.timeout, want.timeout));
            if (got.first_out !== want.first_out)
                report_mismatch($sformatf("first stamp %0h, expected %0h",
                                          got.first_out, want.first_out));
            if (got.last_out !== want.last_out)
                report_mismatch($sformatf("last stamp %0h, expected %0h",
                                          got.last_out, want.last_out));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    prfm_cfg_if cfg_if ();
    prfm_upd_if upd_if ();
    prfm_res_if res_if ();

    pulse_flow_rate_monitor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_upd   (upd_if),
        .o_res   (res_if)
    );

    flow_scoreboard sb = new();

    bit                 calm;
    bit                 pressure_req;
    logic [STAMP_W-1:0] wall_ms;
    logic [STAMP_W-1:0] pulse_ms;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // meter-like updates: advancing time, recent pulse stamps, silences, some noise
    function automatic t_flow_update next_update();
        t_flow_update u;
        int unsigned  kind;
        kind    = $urandom_range(99);
        wall_ms = wall_ms + (($urandom_range(19) == 0) ? $urandom : $urandom_range(4000));
        u.now_ms = wall_ms;
        if (kind < 60) begin
            u.pulses  = PULSE_W'($urandom_range(1, 255));
            u.last_ms = wall_ms - $urandom_range(200);
            if ($urandom_range(19) == 0)
                u.first_ms = u.last_ms + $urandom_range(1, 3000);
            else if ($urandom_range(7) == 0)
                u.first_ms = u.last_ms;
            else
                u.first_ms = u.last_ms - $urandom_range(3000);
            pulse_ms = u.last_ms;
        end else if (kind < 85) begin
            u.pulses   = '0;
            u.first_ms = pulse_ms;
            u.last_ms  = pulse_ms;
        end else if (kind < 90) begin
            u.pulses   = '0;
            u.first_ms = '0;
            u.last_ms  = '0;
        end else begin
            u.pulses   = ($urandom_range(1) == 0) ? '0 : PULSE_W'($urandom);
            u.first_ms = $urandom;
            u.last_ms  = $urandom;
            u.now_ms   = $urandom;
        end
        return u;
    endfunction

    task automatic send_update(t_flow_update u);
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                upd_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        upd_if.valid          <= 1'b1;
        upd_if.pulse_count    <= u.pulses;
        upd_if.first_stamp_ms <= u.first_ms;
        upd_if.last_stamp_ms  <= u.last_ms;
        upd_if.now_ms         <= u.now_ms;
        @(posedge i_clk);
        while (upd_if.ready !== 1'b1)
            @(posedge i_clk);
        sb.note_update(u);
    endtask

    task automatic settle();
        upd_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge i_clk);
        while (cfg_if.ready !== 1'b1)
            @(posedge i_clk);
        sb.write_register(idx, data);
    endtask

    // unused index first: it must leave every register alone
    task automatic apply_settings(logic [31:0] ratio_w, logic [31:0] nominal_w,
                                  logic [31:0] limit_w);
        settle();
        cfg_write(CFG_UNUSED, $urandom);
        cfg_write(CFG_RATIO, ratio_w);
        cfg_write(CFG_NOMINAL, nominal_w);
        cfg_write(CFG_LIMIT, limit_w);
        cfg_if.valid <= 1'b0;
    endtask

    initial begin
        t_flow_result got;
        int           hold_left;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got.rate      = res_if.flow_rate_ml_per_s;
                got.interval  = res_if.interval_ms;
                got.missed    = res_if.missed_count;
                got.timeout   = res_if.pulse_timeout;
                got.first_out = res_if.first_stamp_out;
                got.last_out  = res_if.last_stamp_out;
                sb.check_result(got);
            end
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (pressure_req) begin
                pressure_req = 1'b0;
                hold_left    = HOLD_CYCLES;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((upd_if.valid && upd_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        logic [31:0] ratio_w;
        logic [31:0] nominal_w;
        logic [31:0] limit_w;
        int          phase;
        calm         = 1'b0;
        pressure_req = 1'b0;
        wall_ms      = $urandom;
        pulse_ms     = '0;
        i_rst_n               <= 1'b0;
        cfg_if.valid          <= 1'b0;
        cfg_if.index          <= '0;
        cfg_if.data           <= '0;
        upd_if.valid          <= 1'b0;
        upd_if.pulse_count    <= '0;
        upd_if.first_stamp_ms <= '0;
        upd_if.last_stamp_ms  <= '0;
        upd_if.now_ms         <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: plain rate, saturation, reversed stamps, wrap, timeouts
        send_update('{8'd1, 32'd1000, 32'd2000, 32'd2500});
        send_update('{8'd255, 32'd0, 32'd1, 32'd10});
        send_update('{8'd10, 32'd5000, 32'd5000, 32'd6000});
        send_update('{8'd3, 32'd6000, 32'd5000, 32'd7000});
        send_update('{8'd0, 32'd0, 32'd0, 32'd12345});
        send_update('{8'd0, 32'd100, 32'd100, 32'hFFFF_FFFF});
        send_update('{8'd0, 32'd100, 32'd100, 32'h8000_0064});
        send_update('{8'd0, 32'd100, 32'd100, 32'h8000_0063});
        send_update('{8'd0, 32'd100, 32'd100, 32'hC000_0000});
        send_update('{8'd255, 32'hFFFF_FFF0, 32'h0000_0010, 32'h0000_0020});
        send_update('{8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0});
        send_update('{8'h80, 32'h0000_0001, 32'h8000_0000, 32'h8000_0001});
        send_update('{8'h7F, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000});

        // largest ratio, zero nominal interval, limit of one
        apply_settings(32'hFFF0_0000 | 32'h000F_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_update('{8'd255, 32'd0, 32'd1, 32'd2});
        send_update('{8'd0, 32'd1000, 32'd1000, 32'd1500});
        send_update('{8'd0, 32'd0, 32'd0, 32'd777});
        send_update('{8'd0, 32'd1000, 32'd1000, 32'd3500});

        // zero ratio, limit of zero
        apply_settings(32'd0, 32'd1000, 32'hFFFF_FF00);
        send_update('{8'd200, 32'd100, 32'd900, 32'd1000});
        send_update('{8'd0, 32'd50, 32'd50, 32'd1051});
        send_update('{8'd0, 32'd50, 32'd50, 32'd1050});

        // count misses up, then drop the limit below the count
        apply_settings(32'd500, 32'd10, 32'd255);
        repeat (5) send_update('{8'd0, 32'd100, 32'd100, 32'd200});
        apply_settings(32'd500, 32'd10, 32'd2);
        send_update('{8'd0, 32'd100, 32'd100, 32'd2200});

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                ratio_w   = 32'h000F_FFFF;
                nominal_w = 32'h7FFF_FFFF;
                limit_w   = 32'd255;
            end else if (phase == 1) begin
                ratio_w   = 32'd0;
                nominal_w = 32'd0;
                limit_w   = 32'd1;
            end else begin
                case ($urandom_range(3))
                    0: ratio_w = $urandom_range(1, 2000);
                    1: ratio_w = $urandom & 32'h000F_FFFF;
                    2: ratio_w = 32'h000F_FFFF;
                    default: ratio_w = 32'd0;
                endcase
                case ($urandom_range(3))
                    0: nominal_w = $urandom_range(999);
                    1: nominal_w = $urandom_range(1000, 5000);
                    2: nominal_w = $urandom & 32'h7FFF_FFFF;
                    default: nominal_w = 32'h7FFF_FFFF;
                endcase
                case ($urandom_range(3))
                    0: limit_w = 32'd1;
                    1: limit_w = $urandom_range(2, 8);
                    2: limit_w = $urandom_range(1, 255);
                    default: limit_w = $urandom_range(255);
                endcase
            end
            // upper bits beyond each register width are don't-care
            ratio_w   = ratio_w | ($urandom & 32'hFFF0_0000);
            nominal_w = nominal_w | ($urandom & 32'h8000_0000);
            limit_w   = limit_w | ($urandom & 32'hFFFF_FF00);
            apply_settings(ratio_w, nominal_w, limit_w);
            calm = (phase == CALM_PHASE);
            if (phase == PRESSURE_PHASE)
                pressure_req = 1'b1;
            repeat (PHASE_ITEMS) send_update(next_update());
        end

        settle();
        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
